// ===== hw/rtl/pbgs_pkg.sv =====
// pbgs_pkg: shared types and constants of the poisson blend solver
// depends on nothing; used by every file of the block but pbgs_ram
`timescale 1ns / 1ps

package pbgs_pkg;

  // item modes
  typedef enum logic [1:0] {
    MODE_LOAD_DST = 2'd0,
    MODE_LOAD_SRC = 2'd1,
    MODE_RUN      = 2'd2,
    MODE_READ     = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_DST_WIDTH  = 3'd0,
    CFG_DST_HEIGHT = 3'd1,
    CFG_SRC_WIDTH  = 3'd2,
    CFG_SRC_HEIGHT = 3'd3,
    CFG_OFFSET_ROW = 3'd4,
    CFG_OFFSET_COL = 3'd5,
    CFG_MAX_ITER   = 3'd6,
    CFG_TOLERANCE  = 3'd7
  } cfg_index_e;

  localparam int CFG_DATA_W  = 14;
  localparam int ITER_W      = 14;
  localparam int SIZE_W      = 7;
  localparam int TOL_W       = 8;
  localparam int PIX_W       = 8;
  localparam int INT_BITS    = 13;   // integer bits of the working format
  localparam int GRAD_W      = 11;   // sum of four 8-bit differences

  localparam logic [SIZE_W-1:0] RST_SIZE     = 7'd64;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 14'd10000;

  typedef struct packed {
    mode_e       mode;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [7:0]  pixel_value;
    logic        mask_on;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        pixel_out;
    logic [ITER_W-1:0] iterations_used;
    logic              converged;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RUN_INIT,
    ST_SWEEP_INIT,
    ST_PX_ADDR,
    ST_PX_CHK,
    ST_NB_RD,
    ST_NB_ACC,
    ST_DV_ABS,
    ST_DV_MUL,
    ST_DV_WB,
    ST_PX_NEXT,
    ST_SWEEP_END,
    ST_RUN_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic ld_dst;
    logic ld_src;
    logic rd_issue;
    logic out_read;
    logic run_init;
    logic sweep_init;
    logic px_issue;
    logic px_latch;
    logic nb_issue;
    logic nb_acc;
    logic dv_abs;
    logic dv_mul;
    logic dv_wb;
    logic px_next;
    logic sweep_end;
    logic out_run;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic iter_zero;
    logic iter_last;
    logic px_skip;
    logic px_last;
    logic nb_last;
    logic cnt_zero;
    logic sweep_ok;
  } sts_t;

  // neighbour order: up, left, right, down
  function automatic logic signed [1:0] nbr_dr(input logic [1:0] n);
    logic signed [1:0] r;
    r = 2'sd0;
    case (n)
      2'd0:    r = -2'sd1;
      2'd3:    r = 2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] nbr_dc(input logic [1:0] n);
    logic signed [1:0] r;
    r = 2'sd0;
    case (n)
      2'd1:    r = -2'sd1;
      2'd2:    r = 2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pbgs_ram.sv =====
// pbgs_ram: generic one-write one-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module pbgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pbgs_datapath.sv =====
// pbgs_datapath: config registers, pixel stores, neighbour accumulation,
// mean division and output register; depends on pbgs_pkg and pbgs_ram
`timescale 1ns / 1ps

module pbgs_datapath #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_index_i,
  input  logic [pbgs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  pbgs_pkg::in_word_t                in_word_i,
  input  pbgs_pkg::cmd_t                    cmd_i,
  output pbgs_pkg::sts_t                    sts_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output pbgs_pkg::out_word_t               out_word_o
);

  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int AW   = RW + CW;
  localparam int WW   = pbgs_pkg::INT_BITS + FRACTION_BITS;
  localparam int FW   = WW + 2;
  localparam int SW   = WW + 3;
  localparam int M    = SW - 1;
  localparam int K    = ((M + 1) % 2 == 1) ? M + 1 : M + 2;
  localparam int XW   = (RW > CW) ? ((RW > 7) ? RW : 7) : ((CW > 7) ? CW : 7);
  localparam int DW   = XW + 2;
  localparam int GRAD_W_L = pbgs_pkg::GRAD_W - 1;
  localparam logic [63:0] DIV3_FULL = ((64'd1 << K) + 64'd1) / 64'd3;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (WW - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  // configuration registers
  logic [pbgs_pkg::SIZE_W-1:0] dst_w_q, dst_h_q, src_w_q, src_h_q;
  logic signed [6:0]           off_r_q, off_c_q;
  logic [pbgs_pkg::ITER_W-1:0] max_it_q;
  logic [pbgs_pkg::TOL_W-1:0]  tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_w_q  <= pbgs_pkg::RST_SIZE;
      dst_h_q  <= pbgs_pkg::RST_SIZE;
      src_w_q  <= pbgs_pkg::RST_SIZE;
      src_h_q  <= pbgs_pkg::RST_SIZE;
      off_r_q  <= '0;
      off_c_q  <= '0;
      max_it_q <= pbgs_pkg::RST_MAX_ITER;
      tol_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (pbgs_pkg::cfg_index_e'(cfg_index_i))
        pbgs_pkg::CFG_DST_WIDTH:  dst_w_q  <= cfg_data_i[6:0];
        pbgs_pkg::CFG_DST_HEIGHT: dst_h_q  <= cfg_data_i[6:0];
        pbgs_pkg::CFG_SRC_WIDTH:  src_w_q  <= cfg_data_i[6:0];
        pbgs_pkg::CFG_SRC_HEIGHT: src_h_q  <= cfg_data_i[6:0];
        pbgs_pkg::CFG_OFFSET_ROW: off_r_q  <= $signed(cfg_data_i[6:0]);
        pbgs_pkg::CFG_OFFSET_COL: off_c_q  <= $signed(cfg_data_i[6:0]);
        pbgs_pkg::CFG_MAX_ITER:   max_it_q <= cfg_data_i;
        pbgs_pkg::CFG_TOLERANCE:  tol_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sizes saturated to 1 .. maximum
  logic [CW:0] dw, sw;
  logic [RW:0] dh, sh;

  always_comb begin
    dw = (dst_w_q == '0) ? (CW+1)'(1) :
         (int'(dst_w_q) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(dst_w_q);
    sw = (src_w_q == '0) ? (CW+1)'(1) :
         (int'(src_w_q) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(src_w_q);
    dh = (dst_h_q == '0) ? (RW+1)'(1) :
         (int'(dst_h_q) > MAX_HEIGHT) ? (RW+1)'(MAX_HEIGHT) : (RW+1)'(dst_h_q);
    sh = (src_h_q == '0) ? (RW+1)'(1) :
         (int'(src_h_q) > MAX_HEIGHT) ? (RW+1)'(MAX_HEIGHT) : (RW+1)'(src_h_q);
  end

  logic signed [DW-1:0] dw_s, dh_s, sw_s, sh_s;
  assign dw_s = $signed({{(DW-CW-1){1'b0}}, dw});
  assign sw_s = $signed({{(DW-CW-1){1'b0}}, sw});
  assign dh_s = $signed({{(DW-RW-1){1'b0}}, dh});
  assign sh_s = $signed({{(DW-RW-1){1'b0}}, sh});

  // sweep position and neighbour counter
  logic [RW-1:0] i_q;
  logic [CW-1:0] j_q;
  logic [1:0]    n_q;

  logic signed [DW-1:0] i_s, j_s, ti, tj, ni, nj, si, sj;
  logic                 t_in, dn_in, sn_in;

  assign i_s = $signed({{(DW-RW){1'b0}}, i_q});
  assign j_s = $signed({{(DW-CW){1'b0}}, j_q});
  assign ti  = i_s + DW'(off_r_q);
  assign tj  = j_s + DW'(off_c_q);
  assign ni  = ti + DW'(pbgs_pkg::nbr_dr(n_q));
  assign nj  = tj + DW'(pbgs_pkg::nbr_dc(n_q));
  assign si  = i_s + DW'(pbgs_pkg::nbr_dr(n_q));
  assign sj  = j_s + DW'(pbgs_pkg::nbr_dc(n_q));

  assign t_in  = (ti >= 0) && (tj >= 0) && (ti < dh_s) && (tj < dw_s);
  assign dn_in = (ni >= 0) && (nj >= 0) && (ni < dh_s) && (nj < dw_s);
  assign sn_in = (si >= 0) && (sj >= 0) && (si < sh_s) && (sj < sw_s);

  logic [AW-1:0] cur_addr, tgt_addr, nbr_addr, snb_addr, in_addr;
  assign cur_addr = {i_q, j_q};
  assign tgt_addr = {ti[RW-1:0], tj[CW-1:0]};
  assign nbr_addr = {ni[RW-1:0], nj[CW-1:0]};
  assign snb_addr = {si[RW-1:0], sj[CW-1:0]};
  assign in_addr  = {RW'(in_word_i.row), CW'(in_word_i.col)};

  logic in_inside;
  assign in_inside = (int'(in_word_i.row) < MAX_HEIGHT) && (int'(in_word_i.col) < MAX_WIDTH);

  // stores
  logic            wk_we, sr_we;
  logic [AW-1:0]   wk_waddr, wk_raddr, sr_raddr;
  logic [WW-1:0]   wk_wdata, wk_rdata;
  logic [8:0]      sr_rdata;
  logic [WW-1:0]   fp;

  always_comb begin
    wk_we    = (cmd_i.ld_dst && in_inside) || cmd_i.dv_wb;
    wk_waddr = cmd_i.dv_wb ? tgt_addr : in_addr;
    wk_wdata = cmd_i.dv_wb ? fp : (WW'(in_word_i.pixel_value) << FRACTION_BITS);
    sr_we    = cmd_i.ld_src && in_inside;
    wk_raddr = cmd_i.rd_issue ? in_addr : (cmd_i.px_issue ? tgt_addr : nbr_addr);
    sr_raddr = cmd_i.px_issue ? cur_addr : snb_addr;
  end

  pbgs_ram #(.WIDTH(WW), .DEPTH(1 << AW)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wk_we),
    .waddr_i (wk_waddr),
    .wdata_i (wk_wdata),
    .raddr_i (wk_raddr),
    .rdata_o (wk_rdata)
  );

  // mask bit on top of the 8-bit source sample
  pbgs_ram #(.WIDTH(9), .DEPTH(1 << AW)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (sr_we),
    .waddr_i (in_addr),
    .wdata_i ({in_word_i.mask_on, in_word_i.pixel_value}),
    .raddr_i (sr_raddr),
    .rdata_o (sr_rdata)
  );

  // per-pixel accumulation and division
  logic [7:0]              src_c_q;
  logic signed [WW-1:0]    old_q;
  logic signed [FW-1:0]    sum_f_q;
  logic signed [GRAD_W_L:0] sum_g_q;
  logic [2:0]              cnt_q;
  logic                    neg_q;
  logic [M-1:0]            abs_q, quo_q;
  logic signed [SW-1:0]    sum_all;
  logic [M+K-1:0]          prod;

  assign sum_all = SW'(sum_f_q) + (SW'(sum_g_q) <<< FRACTION_BITS);
  assign prod    = (M+K)'(abs_q) * (M+K)'(DIV3_FULL[K-1:0]);

  logic signed [SW-1:0] fp_full;
  logic signed [WW:0]   diff;
  logic [WW:0]          adiff;

  always_comb begin
    fp_full = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    if (fp_full > SAT_HI) begin
      fp = SAT_HI[WW-1:0];
    end else if (fp_full < SAT_LO) begin
      fp = SAT_LO[WW-1:0];
    end else begin
      fp = fp_full[WW-1:0];
    end
    diff  = $signed({fp[WW-1], fp}) - $signed({old_q[WW-1], old_q});
    adiff = diff[WW] ? (WW+1)'(-diff) : (WW+1)'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.px_latch) begin
      src_c_q <= sr_rdata[7:0];
      old_q   <= $signed(wk_rdata);
      sum_f_q <= '0;
      sum_g_q <= '0;
    end else if (cmd_i.nb_acc && dn_in) begin
      sum_f_q <= sum_f_q + FW'($signed(wk_rdata));
      if (sn_in) begin
        sum_g_q <= sum_g_q + ($signed({3'b0, src_c_q}) - $signed({3'b0, sr_rdata[7:0]}));
      end
    end
    if (cmd_i.dv_abs) begin
      neg_q <= sum_all[SW-1];
      abs_q <= sum_all[SW-1] ? M'(-sum_all) : M'(sum_all);
    end
    if (cmd_i.dv_mul) begin
      case (cnt_q)
        3'd1:    quo_q <= abs_q;
        3'd2:    quo_q <= abs_q >> 1;
        3'd3:    quo_q <= prod[M+K-1:K];
        default: quo_q <= abs_q >> 2;
      endcase
    end
  end

  // control state of the run
  logic [pbgs_pkg::ITER_W-1:0] count_q;
  logic                        done_q, ok_q, rd_in_q, out_valid_q;
  pbgs_pkg::out_word_t         out_q;
  logic [7:0]                  rd_pix;

  always_comb begin
    if (wk_rdata[WW-1]) begin
      rd_pix = '0;
    end else if (wk_rdata[WW-2:FRACTION_BITS] > (WW-1-FRACTION_BITS)'(255)) begin
      rd_pix = 8'd255;
    end else begin
      rd_pix = wk_rdata[FRACTION_BITS+7:FRACTION_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      ok_q        <= 1'b0;
      rd_in_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rd_issue) begin
        rd_in_q <= in_inside;
      end
      if (cmd_i.run_init) begin
        count_q <= '0;
        done_q  <= 1'b0;
      end
      if (cmd_i.sweep_init) begin
        i_q  <= '0;
        j_q  <= '0;
        ok_q <= 1'b1;
      end
      if (cmd_i.px_latch) begin
        n_q   <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.nb_acc) begin
        n_q <= n_q + 2'd1;
        if (dn_in) begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
      if (cmd_i.dv_wb && (adiff > (WW+1)'(tol_q))) begin
        ok_q <= 1'b0;
      end
      if (cmd_i.px_next) begin
        if ((CW+1)'(j_q) + (CW+1)'(1) == sw) begin
          j_q <= '0;
          i_q <= i_q + RW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
      if (cmd_i.sweep_end) begin
        count_q <= count_q + pbgs_pkg::ITER_W'(1);
        if (ok_q) begin
          done_q <= 1'b1;
        end
      end
      if (cmd_i.out_read || cmd_i.out_run) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_read) begin
      out_q.pixel_out       <= rd_in_q ? rd_pix : 8'd0;
      out_q.iterations_used <= count_q;
      out_q.converged       <= done_q;
    end else if (cmd_i.out_run) begin
      out_q.pixel_out       <= 8'd0;
      out_q.iterations_used <= count_q;
      out_q.converged       <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    sts_o.iter_zero = (max_it_q == '0);
    sts_o.iter_last = ({1'b0, count_q} + 15'd1) >= {1'b0, max_it_q};
    sts_o.px_skip   = !sr_rdata[8] || !t_in;
    sts_o.px_last   = ((RW+1)'(i_q) + (RW+1)'(1) == sh) &&
                      ((CW+1)'(j_q) + (CW+1)'(1) == sw);
    sts_o.nb_last   = (n_q == 2'd3);
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.sweep_ok  = ok_q;
  end

  // a division result is only formed for a pixel with neighbours
  a_wb_has_nbr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dv_wb |-> (cnt_q != '0) && (cnt_q <= 3'd4))
    else $error("write-back without neighbours");

  // a result word never overwrites one still waiting
  a_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_read || cmd_i.out_run) |-> !out_valid_q)
    else $error("result word overwritten");

  // a sweep with no large change ends the run as converged
  a_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_end && ok_q |=> done_q && (count_q == $past(count_q) + 14'd1))
    else $error("converged flag not set");

endmodule

// ===== hw/rtl/pbgs_ctrl.sv =====
// pbgs_ctrl: controller state machine of the poisson blend solver
// depends on pbgs_pkg; drives pbgs_datapath through command and status words
`timescale 1ns / 1ps

module pbgs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  pbgs_pkg::mode_e    in_mode_i,
  output logic               in_stall_o,
  input  pbgs_pkg::sts_t     sts_i,
  output pbgs_pkg::cmd_t     cmd_o
);

  pbgs_pkg::state_e state_q, state_d;
  logic             is_load, accept;

  assign is_load = (in_mode_i == pbgs_pkg::MODE_LOAD_DST) ||
                   (in_mode_i == pbgs_pkg::MODE_LOAD_SRC);
  assign in_stall_o = !((state_q == pbgs_pkg::ST_IDLE) && (sts_i.out_free || is_load));
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbgs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      pbgs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_mode_i)
            pbgs_pkg::MODE_LOAD_DST: cmd_o.ld_dst = 1'b1;
            pbgs_pkg::MODE_LOAD_SRC: cmd_o.ld_src = 1'b1;
            pbgs_pkg::MODE_READ: begin
              cmd_o.rd_issue = 1'b1;
              state_d        = pbgs_pkg::ST_RD_WAIT;
            end
            default: state_d = pbgs_pkg::ST_RUN_INIT;
          endcase
        end
      end
      pbgs_pkg::ST_RD_WAIT: begin
        cmd_o.out_read = 1'b1;
        state_d        = pbgs_pkg::ST_IDLE;
      end
      pbgs_pkg::ST_RUN_INIT: begin
        cmd_o.run_init = 1'b1;
        state_d = sts_i.iter_zero ? pbgs_pkg::ST_RUN_DONE : pbgs_pkg::ST_SWEEP_INIT;
      end
      pbgs_pkg::ST_SWEEP_INIT: begin
        cmd_o.sweep_init = 1'b1;
        state_d          = pbgs_pkg::ST_PX_ADDR;
      end
      pbgs_pkg::ST_PX_ADDR: begin
        cmd_o.px_issue = 1'b1;
        state_d        = pbgs_pkg::ST_PX_CHK;
      end
      pbgs_pkg::ST_PX_CHK: begin
        cmd_o.px_latch = 1'b1;
        state_d = sts_i.px_skip ? pbgs_pkg::ST_PX_NEXT : pbgs_pkg::ST_NB_RD;
      end
      pbgs_pkg::ST_NB_RD: begin
        cmd_o.nb_issue = 1'b1;
        state_d        = pbgs_pkg::ST_NB_ACC;
      end
      pbgs_pkg::ST_NB_ACC: begin
        cmd_o.nb_acc = 1'b1;
        state_d = sts_i.nb_last ? pbgs_pkg::ST_DV_ABS : pbgs_pkg::ST_NB_RD;
      end
      pbgs_pkg::ST_DV_ABS: begin
        if (sts_i.cnt_zero) begin
          state_d = pbgs_pkg::ST_PX_NEXT;
        end else begin
          cmd_o.dv_abs = 1'b1;
          state_d      = pbgs_pkg::ST_DV_MUL;
        end
      end
      pbgs_pkg::ST_DV_MUL: begin
        cmd_o.dv_mul = 1'b1;
        state_d      = pbgs_pkg::ST_DV_WB;
      end
      pbgs_pkg::ST_DV_WB: begin
        cmd_o.dv_wb = 1'b1;
        state_d     = pbgs_pkg::ST_PX_NEXT;
      end
      pbgs_pkg::ST_PX_NEXT: begin
        cmd_o.px_next = 1'b1;
        state_d = sts_i.px_last ? pbgs_pkg::ST_SWEEP_END : pbgs_pkg::ST_PX_ADDR;
      end
      pbgs_pkg::ST_SWEEP_END: begin
        cmd_o.sweep_end = 1'b1;
        state_d = (sts_i.sweep_ok || sts_i.iter_last) ? pbgs_pkg::ST_RUN_DONE
                                                      : pbgs_pkg::ST_SWEEP_INIT;
      end
      pbgs_pkg::ST_RUN_DONE: begin
        cmd_o.out_run = 1'b1;
        state_d       = pbgs_pkg::ST_IDLE;
      end
      default: state_d = pbgs_pkg::ST_IDLE;
    endcase
  end

  // words are only taken between runs
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == pbgs_pkg::ST_IDLE))
    else $error("word accepted while busy");

  // a read always produces its result on the next cycle
  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> cmd_o.out_read)
    else $error("read result lost");

  // a sweep with no large change ends the run in a result
  a_sweep_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sweep_end && sts_i.sweep_ok |=> cmd_o.out_run)
    else $error("converged run did not finish");

endmodule

// ===== hw/rtl/poisson_blend_gauss_seidel.sv =====
// poisson_blend_gauss_seidel: one-channel poisson blending by gauss-seidel sweeps
// sequence: a load word is stored at its accepting edge; a read word first reads
// the store, then its result is registered in the output register; a run steps
// through run init, sweeps (per masked pixel: neighbour reads, divide, write-back)
// and run done, all served by one shared accumulate/divide unit
// throughput: one load word per cycle while idle; read and run words one at a time
// reset: async active-low, config to defaults, run counters cleared, stores undefined
`timescale 1ns / 1ps

module poisson_blend_gauss_seidel #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [pbgs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input word channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pbgs_pkg::in_word_t               in_word_i,
  // result word channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pbgs_pkg::out_word_t              out_word_o
);

  // command and status words between the controller and the datapath
  pbgs_pkg::cmd_t cmd;
  pbgs_pkg::sts_t sts;

  // controller sequences loads, reads and the sweep loop pixel by pixel
  pbgs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_word_i.mode),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the stores, the neighbour accumulator, the mean divider
  // and the output register
  pbgs_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
